>>> sv/pcmmn_pkg.sv
package pcmmn_pkg;

    localparam int FRAME_PIXELS_DEF = 16384;
    localparam int SAMPLE_BITS_DEF  = 16;

    // Width of every sample field and clamp register on the ports.
    localparam int FIELD_BITS = 16;

    // Scale factors are floor(255 * 2^24 / range), held in 32 bits.
    localparam int               SCALE_BITS     = 32;
    localparam logic [31:0]      SCALE_DIVIDEND = 32'hFF00_0000;
    localparam logic [15:0]      OUT_MAX        = 16'hFF00;

    localparam int               CFG_INDEX_BITS   = 2;
    localparam logic [1:0]       CFG_CLAMP_ENABLE = 2'd0;
    localparam logic [1:0]       CFG_CLAMP_LOW    = 2'd1;
    localparam logic [1:0]       CFG_CLAMP_HIGH   = 2'd2;

    localparam logic             OP_LOAD  = 1'b0;
    localparam logic             OP_FETCH = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] pixel_blue;
        logic signed [15:0] pixel_green;
        logic signed [15:0] pixel_red;
        logic               frame_end;
    } pixel_t;

    typedef struct packed {
        logic [15:0] out_blue;
        logic [15:0] out_green;
        logic [15:0] out_red;
        logic        out_last;
    } result_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic div_start;
        logic mem_read;
        logic diff;
        logic mul;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic fetch_ok;
        logic out_free;
    } ctrl_status_t;

endpackage

>>> sv/per_channel_minmax_normalizer_top.sv
// A load passes through the load state; a fetch of a ready frame passes through the fetch,
// read, multiply and emit states and waits in emit while a held result blocks its output.
// The load that ends a frame also waits while one shared restoring divider
// produces the three channel scales, one quotient bit per cycle.
// Items are handled one at a time; a waiting result does not block the next transfer.
// Reset (rst_n, asynchronous, active low) empties the frame and restores the clamp registers;
// the frame store is not cleared.
module per_channel_minmax_normalizer_top
    import pcmmn_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pixel_valid,
    output logic                      pixel_stall,
    input  pixel_t                    pixel_data,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result_data,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_data
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    pcmmn_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .operation   (pixel_data.operation),
        .frame_end   (pixel_data.frame_end),
        .pixel_stall (pixel_stall),
        .status      (status),
        .cmd         (cmd)
    );

    pcmmn_dp #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_data   (pixel_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule

>>> sv/pcmmn_ctrl.sv
module pcmmn_ctrl
    import pcmmn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pixel_valid,
    input  logic         operation,
    input  logic         frame_end,
    output logic         pixel_stall,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOAD     = 3'd1;
    localparam logic [2:0] S_LOAD_END = 3'd2;
    localparam logic [2:0] S_DIV      = 3'd3;
    localparam logic [2:0] S_FETCH    = 3'd4;
    localparam logic [2:0] S_READ     = 3'd5;
    localparam logic [2:0] S_MUL      = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign pixel_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (pixel_valid)
                begin
                    cmd.capture = 1'b1;
                    if (operation == OP_FETCH)
                        state_next = S_FETCH;
                    else if (frame_end)
                        state_next = S_LOAD_END;
                    else
                        state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_IDLE;
            end
            S_LOAD_END:
            begin
                cmd.load      = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!status.div_busy)
                    state_next = S_IDLE;
            end
            S_FETCH:
            begin
                if (status.fetch_ok)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Wait until the output register can take the new result.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/pcmmn_dp.sv
module pcmmn_dp
    import pcmmn_pkg::*;
#(
    parameter int FRAME_PIXELS = FRAME_PIXELS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pixel_t                    pixel_data,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_data,
    input  ctrl_cmd_t                 cmd,
    output ctrl_status_t              status,
    input  logic                      result_stall,
    output logic                      result_valid,
    output result_t                   result_data
);

    // Stored samples are wide enough for both the input samples and the clamp limits.
    localparam int SW         = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
    localparam int AW         = $clog2(FRAME_PIXELS);
    localparam int CW         = $clog2(FRAME_PIXELS + 1);
    localparam int PW         = SW + SCALE_BITS;
    localparam int STEP_BITS  = $clog2(SCALE_BITS);
    localparam logic [CW-1:0]        STORE_LIMIT = CW'(FRAME_PIXELS);
    localparam logic [STEP_BITS-1:0] LAST_STEP   = STEP_BITS'(SCALE_BITS - 1);
    localparam logic [PW:0]          ROUND_HALF  = (PW + 1)'(32768);

    function automatic logic signed [SW-1:0] extend_sample(input logic [FIELD_BITS-1:0] f);
        logic [31:0]   w;
        logic [SW-1:0] e;
        w = {16'b0, f};
        for (int i = 0; i < SW; i++)
            e[i] = (i < SAMPLE_BITS) ? w[i] : w[SAMPLE_BITS-1];
        return e;
    endfunction

    // Configuration registers
    logic               clamp_en_reg;
    logic signed [15:0] clamp_low_reg;
    logic signed [15:0] clamp_high_reg;

    // Captured input item
    pixel_t pix_reg;

    // Frame statistics and readout state
    logic signed [SW-1:0]   min_reg   [3];
    logic signed [SW-1:0]   min_next  [3];
    logic signed [SW-1:0]   max_reg   [3];
    logic signed [SW-1:0]   max_next  [3];
    logic [SCALE_BITS-1:0]  scale_reg [3];
    logic [SCALE_BITS-1:0]  scale_next[3];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [AW-1:0]          read_index_reg;
    logic [AW-1:0]          read_index_next;
    logic                   frame_ready_reg;
    logic                   frame_ready_next;

    // Shared restoring divider
    logic                   div_active_reg;
    logic                   div_active_next;
    logic [1:0]             div_chan_reg;
    logic [1:0]             div_chan_next;
    logic [STEP_BITS-1:0]   div_step_reg;
    logic [STEP_BITS-1:0]   div_step_next;
    logic [SW-1:0]          rem_reg;
    logic [SW-1:0]          rem_next;
    logic [SCALE_BITS-1:0]  quo_reg;
    logic [SCALE_BITS-1:0]  quo_next;

    // Readout pipeline
    logic [3*SW-1:0]        mem [FRAME_PIXELS];
    logic [3*SW-1:0]        rd_word_reg;
    logic [SW-1:0]          diff_reg [3];
    logic [PW-1:0]          prod_reg [3];
    logic                   out_valid_reg;
    logic                   out_valid_next;
    result_t                out_reg;

    // Load path
    logic signed [SW-1:0]   lo_ext;
    logic signed [SW-1:0]   hi_ext;
    logic signed [SW-1:0]   raw    [3];
    logic signed [SW-1:0]   sample [3];
    logic [CW-1:0]          eff_count;
    logic                   store_ok;
    logic [3*SW-1:0]        wr_word;

    // Divider path
    logic [SW-1:0]          range_c [3];
    logic [SW:0]            range_wide [3];
    logic [SW-1:0]          divisor;
    logic [SW:0]            partial;
    logic [SW+1:0]          trial;
    logic                   qbit;
    logic                   div_last;

    // Readout arithmetic
    logic signed [SW:0]     diff_wide [3];
    logic [SW-1:0]          diff_next [3];
    logic [PW:0]            rounded   [3];
    logic [PW-16:0]         shifted   [3];
    logic [15:0]            stretched [3];
    logic                   is_last;
    logic                   fetch_ok;
    logic                   out_free;

    assign lo_ext = SW'(clamp_low_reg);
    assign hi_ext = SW'(clamp_high_reg);

    assign raw[0] = extend_sample(pix_reg.pixel_blue);
    assign raw[1] = extend_sample(pix_reg.pixel_green);
    assign raw[2] = extend_sample(pix_reg.pixel_red);

    // Clamping applies the upper limit first, so crossed limits leave the lower one.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sample[c] = raw[c];
            if (clamp_en_reg)
            begin
                if (sample[c] > hi_ext)
                    sample[c] = hi_ext;
                if (sample[c] < lo_ext)
                    sample[c] = lo_ext;
            end
        end
    end

    // A load during readout drops the pending frame and starts over at entry zero.
    assign eff_count = frame_ready_reg ? '0 : count_reg;
    assign store_ok  = (eff_count < STORE_LIMIT);
    assign wr_word   = {sample[2], sample[1], sample[0]};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            range_wide[c] = (SW + 1)'(max_reg[c]) - (SW + 1)'(min_reg[c]);
            range_c[c]    = range_wide[c][SW-1:0];
        end
    end

    always_comb
    begin
        case (div_chan_reg)
            2'd0:    divisor = range_c[0];
            2'd1:    divisor = range_c[1];
            default: divisor = range_c[2];
        endcase
    end

    assign partial  = {rem_reg, quo_reg[SCALE_BITS-1]};
    assign trial    = {1'b0, partial} - {2'b0, divisor};
    assign qbit     = !trial[SW+1];
    assign div_last = (div_step_reg == LAST_STEP);

    assign fetch_ok = frame_ready_reg && (CW'(read_index_reg) < count_reg);
    assign is_last  = ((CW'(read_index_reg) + CW'(1)) == count_reg);
    assign out_free = !out_valid_reg || !result_stall;

    assign status.div_busy = div_active_reg;
    assign status.fetch_ok = fetch_ok;
    assign status.out_free = out_free;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            diff_wide[c] = (SW + 1)'($signed(rd_word_reg[c*SW +: SW])) - (SW + 1)'(min_reg[c]);
            diff_next[c] = diff_wide[c][SW] ? '0 : diff_wide[c][SW-1:0];
            rounded[c]   = {1'b0, prod_reg[c]} + ROUND_HALF;
            shifted[c]   = rounded[c][PW:16];
            stretched[c] = (shifted[c] > (PW - 15)'(OUT_MAX)) ? OUT_MAX : shifted[c][15:0];
        end
    end

    // Frame control, statistics and divider sequencing
    always_comb
    begin
        count_next       = count_reg;
        read_index_next  = read_index_reg;
        frame_ready_next = frame_ready_reg;
        div_active_next  = div_active_reg;
        div_chan_next    = div_chan_reg;
        div_step_next    = div_step_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        out_valid_next   = out_valid_reg;
        for (int c = 0; c < 3; c++)
        begin
            min_next[c]   = min_reg[c];
            max_next[c]   = max_reg[c];
            scale_next[c] = scale_reg[c];
        end

        if (cmd.load)
        begin
            frame_ready_next = 1'b0;
            if (frame_ready_reg)
                read_index_next = '0;
            count_next = eff_count;
            if (store_ok)
            begin
                count_next = eff_count + CW'(1);
                for (int c = 0; c < 3; c++)
                begin
                    if (eff_count == '0)
                    begin
                        min_next[c] = sample[c];
                        max_next[c] = sample[c];
                    end
                    else
                    begin
                        if (sample[c] < min_reg[c])
                            min_next[c] = sample[c];
                        if (sample[c] > max_reg[c])
                            max_next[c] = sample[c];
                    end
                end
            end
        end

        if (cmd.div_start)
        begin
            div_active_next = 1'b1;
            div_chan_next   = 2'd0;
            div_step_next   = '0;
            rem_next        = '0;
            quo_next        = SCALE_DIVIDEND;
        end
        else if (div_active_reg)
        begin
            rem_next      = qbit ? trial[SW-1:0] : partial[SW-1:0];
            quo_next      = {quo_reg[SCALE_BITS-2:0], qbit};
            div_step_next = div_step_reg + STEP_BITS'(1);
            if (div_last)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (div_chan_reg == 2'(c))
                        scale_next[c] = (divisor == '0) ? '0 : {quo_reg[SCALE_BITS-2:0], qbit};
                end
                rem_next      = '0;
                quo_next      = SCALE_DIVIDEND;
                div_step_next = '0;
                if (div_chan_reg == 2'd2)
                begin
                    // All three scales are done: the frame is ready for readout.
                    div_active_next  = 1'b0;
                    read_index_next  = '0;
                    frame_ready_next = (count_reg != '0);
                end
                else
                begin
                    div_chan_next = div_chan_reg + 2'd1;
                end
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                frame_ready_next = 1'b0;
                count_next       = '0;
                read_index_next  = '0;
            end
            else
            begin
                read_index_next = read_index_reg + AW'(1);
            end
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_en_reg    <= 1'b0;
            clamp_low_reg   <= 16'sh8000;
            clamp_high_reg  <= 16'sh7FFF;
            count_reg       <= '0;
            read_index_reg  <= '0;
            frame_ready_reg <= 1'b0;
            div_active_reg  <= 1'b0;
            div_chan_reg    <= 2'd0;
            div_step_reg    <= '0;
            out_valid_reg   <= 1'b0;
            for (int c = 0; c < 3; c++)
                scale_reg[c] <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_CLAMP_ENABLE: clamp_en_reg   <= cfg_data[0];
                    CFG_CLAMP_LOW:    clamp_low_reg  <= $signed(cfg_data);
                    CFG_CLAMP_HIGH:   clamp_high_reg <= $signed(cfg_data);
                    default:          ;
                endcase
            end
            count_reg       <= count_next;
            read_index_reg  <= read_index_next;
            frame_ready_reg <= frame_ready_next;
            div_active_reg  <= div_active_next;
            div_chan_reg    <= div_chan_next;
            div_step_reg    <= div_step_next;
            out_valid_reg   <= out_valid_next;
            for (int c = 0; c < 3; c++)
                scale_reg[c] <= scale_next[c];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            pix_reg <= pixel_data;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        for (int c = 0; c < 3; c++)
        begin
            min_reg[c] <= min_next[c];
            max_reg[c] <= max_next[c];
            if (cmd.diff)
                diff_reg[c] <= diff_next[c];
            if (cmd.mul)
                prod_reg[c] <= {{SCALE_BITS{1'b0}}, diff_reg[c]} * {{SW{1'b0}}, scale_reg[c]};
        end
        if (cmd.emit)
        begin
            out_reg.out_blue  <= stretched[0];
            out_reg.out_green <= stretched[1];
            out_reg.out_red   <= stretched[2];
            out_reg.out_last  <= is_last;
        end
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load && store_ok)
            mem[eff_count[AW-1:0]] <= wr_word;
        if (cmd.mem_read)
            rd_word_reg <= mem[read_index_reg];
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

>>> test/minmax_stretch_checker.sv
module minmax_stretch_checker
    import pcmmn_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pixel_valid,
    input  logic                      pixel_stall,
    input  pixel_t                    pixel_data,
    input  logic                      result_valid,
    input  logic                      result_stall,
    input  result_t                   result_data,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]     cfg_data,
    output int                        mismatches,
    output int                        fetches_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = FRAME_PIXELS_DEF;

    logic signed [15:0] stored_px [STORE_DEPTH][3];
    logic signed [15:0] ch_min [3];
    logic signed [15:0] ch_max [3];
    logic [31:0]        ch_scale [3];
    int unsigned        stored_count;
    int unsigned        next_read;
    bit                 readout_open;
    bit                 clamp_on;
    logic signed [15:0] clamp_lo;
    logic signed [15:0] clamp_hi;
    result_t            expected_px [$];

    task automatic reset_model();
        foreach (ch_min[c])
        begin
            ch_min[c] = '0;
            ch_max[c] = '0;
            ch_scale[c] = '0;
        end
        stored_count = 0;
        next_read = 0;
        readout_open = 1'b0;
        clamp_on = 1'b0;
        clamp_lo = 16'sh8000;
        clamp_hi = 16'sh7fff;
        expected_px.delete();
        mismatches = 0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [FIELD_BITS-1:0] data);
        case (idx)
            CFG_CLAMP_ENABLE: clamp_on = data[0];
            CFG_CLAMP_LOW:    clamp_lo = data;
            CFG_CLAMP_HIGH:   clamp_hi = data;
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] clamp_sample(input logic signed [15:0] s);
        logic signed [15:0] v;
        v = s;
        // With crossed limits the lower limit is applied last and wins.
        if (clamp_on)
        begin
            if (v > clamp_hi) v = clamp_hi;
            if (v < clamp_lo) v = clamp_lo;
        end
        return v;
    endfunction

    task automatic compute_scales();
        longint span;
        for (int c = 0; c < 3; c++)
        begin
            span = longint'(ch_max[c]) - longint'(ch_min[c]);
            // A flat channel gets a zero scale and reads back as zero.
            ch_scale[c] = (span == 0) ? 32'd0 : 32'((longint'(255) << 24) / span);
        end
        next_read = 0;
        readout_open = (stored_count != 0);
    endtask

    function automatic logic [15:0] stretch(input logic signed [15:0] s, input int c);
        longint d;
        longint v;
        d = longint'(s) - longint'(ch_min[c]);
        if (d < 0) d = 0;
        v = (d * longint'(ch_scale[c]) + 32768) >>> 16;
        if (v > 65280) v = 65280;
        return v[15:0];
    endfunction

    task automatic apply_item(input pixel_t p);
        logic signed [15:0] raw [3];
        logic signed [15:0] v;
        result_t r;
        raw[0] = p.pixel_blue;
        raw[1] = p.pixel_green;
        raw[2] = p.pixel_red;
        if (p.operation == OP_LOAD)
        begin
            // A load while a readout is open drops that readout.
            if (readout_open)
            begin
                readout_open = 1'b0;
                stored_count = 0;
                next_read = 0;
            end
            if (stored_count < STORE_DEPTH)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    v = clamp_sample(raw[c]);
                    stored_px[stored_count][c] = v;
                    if (stored_count == 0)
                    begin
                        ch_min[c] = v;
                        ch_max[c] = v;
                    end
                    else
                    begin
                        if (v < ch_min[c]) ch_min[c] = v;
                        if (v > ch_max[c]) ch_max[c] = v;
                    end
                end
                stored_count++;
            end
            if (p.frame_end) compute_scales();
        end
        else if (readout_open && next_read < stored_count)
        begin
            r.out_blue  = stretch(stored_px[next_read][0], 0);
            r.out_green = stretch(stored_px[next_read][1], 1);
            r.out_red   = stretch(stored_px[next_read][2], 2);
            r.out_last  = (next_read + 1 == stored_count);
            if (r.out_last)
            begin
                readout_open = 1'b0;
                stored_count = 0;
                next_read = 0;
            end
            else
            begin
                next_read++;
            end
            expected_px.push_back(r);
        end
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (expected_px.size() == 0)
        begin
            mismatches++;
            $error("result transfer with no fetch outstanding");
            return;
        end
        want = expected_px.pop_front();
        if (got.out_blue !== want.out_blue)
        begin
            mismatches++;
            $error("out_blue: expected %0d, got %0d", want.out_blue, got.out_blue);
        end
        if (got.out_green !== want.out_green)
        begin
            mismatches++;
            $error("out_green: expected %0d, got %0d", want.out_green, got.out_green);
        end
        if (got.out_red !== want.out_red)
        begin
            mismatches++;
            $error("out_red: expected %0d, got %0d", want.out_red, got.out_red);
        end
        if (got.out_last !== want.out_last)
        begin
            mismatches++;
            $error("out_last: expected %0d, got %0d", want.out_last, got.out_last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (result_valid && !result_stall) check_result(result_data);
            if (cfg_write) write_reg(cfg_index, cfg_data);
            if (pixel_valid && !pixel_stall) apply_item(pixel_data);
        end
        fetches_in_flight = expected_px.size();
    end

endmodule

>>> test/per_channel_minmax_normalizer_top_test.sv
module per_channel_minmax_normalizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pcmmn_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 128;
    localparam int PHASE_ITEMS  = 260;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      pixel_valid = 1'b0;
    logic                      pixel_stall;
    pixel_t                    pixel_data = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result_data;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_CLAMP_ENABLE;
    logic [FIELD_BITS-1:0]     cfg_data = '0;

    int                 mismatches;
    int                 fetches_in_flight;
    int                 items_sent = 0;
    int                 idle_cycles = 0;
    bit                 send_steady = 1'b0;
    bit                 recv_steady = 1'b0;
    int unsigned        stall_left = 0;
    logic signed [15:0] cur_lo = 16'sh8000;
    logic signed [15:0] cur_hi = 16'sh7fff;

    per_channel_minmax_normalizer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_data   (pixel_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    minmax_stretch_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .pixel_valid       (pixel_valid),
        .pixel_stall       (pixel_stall),
        .pixel_data        (pixel_data),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result_data       (result_data),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .fetches_in_flight (fetches_in_flight)
    );

    always #5ns clk = ~clk;

    // Result side: each result is held off for a drawn number of cycles,
    // with occasional runs where it is taken at once.
    always @(posedge clk)
    begin
        if (result_valid && !result_stall)
        begin
            if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
            stall_left = recv_steady ? 0 : $urandom_range(0, 6);
        end
        else if (result_valid && stall_left != 0)
        begin
            stall_left--;
        end
        result_stall <= (stall_left != 0);
    end

    always @(posedge clk)
    begin
        if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("per_channel_minmax_normalizer_top_test failed");
            $finish;
        end
    end

    function automatic pixel_t load_px(input logic signed [15:0] b, g, r, input logic last);
        pixel_t p;
        p.operation   = OP_LOAD;
        p.pixel_blue  = b;
        p.pixel_green = g;
        p.pixel_red   = r;
        p.frame_end   = last;
        return p;
    endfunction

    // Sample and end fields of a fetch are ignored, so they carry noise.
    function automatic pixel_t fetch_px();
        pixel_t p;
        p.operation   = OP_FETCH;
        p.pixel_blue  = 16'($urandom);
        p.pixel_green = 16'($urandom);
        p.pixel_red   = 16'($urandom);
        p.frame_end   = 1'($urandom);
        return p;
    endfunction

    function automatic logic signed [15:0] draw_sample(input int style, input int base);
        int v;
        case (style)
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = base + int'($urandom_range(0, 16)) - 8;
            2: v = base;
            3: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            default: v = (($urandom_range(0, 1) != 0) ? int'(cur_hi) : int'(cur_lo))
                         + int'($urandom_range(0, 8)) - 4;
        endcase
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic send_item(input pixel_t p);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_data <= p;
        @(posedge clk);
        while (pixel_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic pause_for_results();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (fetches_in_flight != 0) @(posedge clk);
    endtask

    // The frame-end divide and a fetch with no result give no sign of
    // completion, so allow for them before touching the registers.
    task automatic quiesce();
        pause_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_clamps(input bit en, input logic signed [15:0] lo, hi);
        cfg_write <= 1'b1;
        cfg_index <= CFG_CLAMP_ENABLE;
        cfg_data  <= {15'd0, en};
        @(posedge clk);
        cfg_index <= CFG_CLAMP_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_CLAMP_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_lo = lo;
        cur_hi = hi;
    endtask

    task automatic random_frame();
        int n;
        int kind;
        int end_at;
        int fetches;
        int style [3];
        int base [3];
        logic signed [15:0] s [3];
        kind = $urandom_range(0, 19);
        if (kind < 14)
            n = $urandom_range(1, 8);
        else if (kind < 19)
            n = $urandom_range(9, 40);
        else
            n = $urandom_range(41, 160);
        for (int c = 0; c < 3; c++)
        begin
            style[c] = $urandom_range(0, 4);
            base[c] = int'($urandom_range(0, 65535)) - 32768;
        end
        send_steady = ($urandom_range(0, 3) == 0);
        // Mostly clean frames; sometimes the end mark comes early, so the
        // remaining loads reopen a new, unfinished frame.
        end_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n - 1;
        if ($urandom_range(0, 9) == 0) send_item(fetch_px());
        for (int i = 0; i < n; i++)
        begin
            for (int c = 0; c < 3; c++) s[c] = draw_sample(style[c], base[c]);
            send_item(load_px(s[0], s[1], s[2], i == end_at));
        end
        kind = $urandom_range(0, 7);
        if (kind == 0)
            fetches = n + $urandom_range(1, 2);
        else if (kind == 1)
            fetches = $urandom_range(0, n - 1);
        else
            fetches = n;
        for (int i = 0; i < fetches; i++) send_item(fetch_px());
        if ($urandom_range(0, 5) == 0) pause_for_results();
    endtask

    initial
    begin
        bit                 en;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] t;
        int                 target;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the clamp registers at their reset values.
        send_item(fetch_px());
        send_item(load_px(16'sh8000, 16'sh7fff, 16'sd7, 1'b0));
        send_item(load_px(16'sh7fff, 16'sh8000, 16'sd7, 1'b0));
        send_item(load_px(16'sd0, 16'sd0, 16'sd7, 1'b0));
        send_item(load_px(-16'sd1, 16'sd1, 16'sd7, 1'b1));
        repeat (5) send_item(fetch_px());
        send_item(load_px(16'sd10, 16'sd20, 16'sd30, 1'b0));
        send_item(load_px(16'sd11, 16'sd21, 16'sd31, 1'b0));
        send_item(load_px(16'sd12, 16'sd22, 16'sd32, 1'b1));
        send_item(fetch_px());
        // A new single-pixel frame cuts the readout short; every channel is flat.
        send_item(load_px(16'sd5, 16'sd5, 16'sd5, 1'b1));
        repeat (2) send_item(fetch_px());

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:
                begin
                    en = 1'b1; lo = -16'sd100; hi = 16'sd100;
                end
                1:
                begin
                    en = 1'b1; lo = 16'sh8000; hi = 16'sh7fff;
                end
                2:
                begin
                    en = 1'b1; lo = 16'sd300; hi = -16'sd300;
                end
                3:
                begin
                    en = 1'b1; lo = 16'sh7fff; hi = 16'sh7fff;
                end
                4:
                begin
                    en = 1'b1; lo = 16'sh8000; hi = 16'sh8000;
                end
                5:
                begin
                    en = 1'b1;
                    lo = 16'($urandom);
                    hi = 16'($urandom);
                    if (lo > hi)
                    begin
                        t = lo; lo = hi; hi = t;
                    end
                end
                default:
                begin
                    en = 1'b0; lo = 16'($urandom); hi = 16'($urandom);
                end
            endcase
            quiesce();
            program_clamps(en, lo, hi);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_frame();
        end

        quiesce();
        if (mismatches == 0 && fetches_in_flight == 0)
            $display("per_channel_minmax_normalizer_top_test passed");
        else
            $display("per_channel_minmax_normalizer_top_test failed");
        $finish;
    end

endmodule

>>> sim.f
sv/pcmmn_pkg.sv
sv/pcmmn_ctrl.sv
sv/pcmmn_dp.sv
sv/per_channel_minmax_normalizer_top.sv
test/minmax_stretch_checker.sv
test/per_channel_minmax_normalizer_top_test.sv
